// ----- hdl/bpt_pkg.sv -----
// Shared types and constants of the Bezier point and tangent unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package bpt_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 48;
    localparam int TAN_W   = 40;
    localparam int IDX_W   = 4;
    localparam int DEG_W   = 4;
    localparam int CNT_W   = 5;

    localparam logic ACTION_LOAD = 1'b0;
    localparam logic ACTION_EVAL = 1'b1;

    typedef struct packed {
        logic             load;
        logic             cap;
        logic             rb_init;
        logic             pascal;
        logic             diff;
        logic             hinit;
        logic             hmul;
        logic             hadd;
        logic             out_load;
        logic [CNT_W-1:0] deg;
        logic [CNT_W-1:0] idx;
    } t_cmd;

endpackage
`default_nettype wire

// ----- hdl/bpt_req_if.sv -----
// Request channel of the Bezier point and tangent unit.
// Depends on bpt_pkg for field widths.
`default_nettype none
interface bpt_req_if #(
    parameter int T_FRAC_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [bpt_pkg::IDX_W-1:0]           point_index;
    logic signed [bpt_pkg::COORD_W-1:0]  point_x;
    logic signed [bpt_pkg::COORD_W-1:0]  point_y;
    logic [T_FRAC_BITS:0]                param_t;

    modport source (output valid, action, point_index, point_x, point_y, param_t,
                    input ready);
    modport sink   (input valid, action, point_index, point_x, point_y, param_t,
                    output ready);
endinterface
`default_nettype wire

// ----- hdl/bpt_rsp_if.sv -----
// Result channel of the Bezier point and tangent unit.
// Depends on bpt_pkg for field widths.
`default_nettype none
interface bpt_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bpt_pkg::COORD_W-1:0]  pos_x;
    logic signed [bpt_pkg::COORD_W-1:0]  pos_y;
    logic signed [bpt_pkg::TAN_W-1:0]    tangent_x;
    logic signed [bpt_pkg::TAN_W-1:0]    tangent_y;

    modport source (output valid, pos_x, pos_y, tangent_x, tangent_y, input ready);
    modport sink   (input valid, pos_x, pos_y, tangent_x, tangent_y, output ready);
endinterface
`default_nettype wire

// ----- hdl/bpt_ctrl.sv -----
// Controller: degree register, stale flag, sequencing of rebuild and Horner steps.
// Depends on bpt_pkg (t_cmd, widths, action codes).
`default_nettype none
module bpt_ctrl #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bpt_pkg::DEG_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_req_valid,
    output logic                            o_req_ready,
    input  wire logic                       i_req_action,
    input  wire logic [bpt_pkg::IDX_W-1:0]  i_req_index,
    output logic                            o_rsp_valid,
    input  wire logic                       i_rsp_ready,
    output bpt_pkg::t_cmd                   o_cmd
);
    localparam int CW = bpt_pkg::CNT_W;
    localparam logic [CW-1:0] MAXD = CW'(MAX_DEGREE);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_PASCAL = 4'd2;
    localparam logic [3:0] S_DIFF   = 4'd3;
    localparam logic [3:0] S_DRAIN  = 4'd4;
    localparam logic [3:0] S_HINIT  = 4'd5;
    localparam logic [3:0] S_HMUL   = 4'd6;
    localparam logic [3:0] S_HADD   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]                 r_state, n_state;
    logic [CW-1:0]              r_cnt, n_cnt;
    logic [bpt_pkg::DEG_W-1:0]  r_deg;
    logic                       r_stale, n_stale;
    logic                       r_ovalid, n_ovalid;
    logic [CW-1:0]              deg5, n_used;
    logic                       accept, idx_ok;

    assign deg5   = CW'(r_deg);
    assign n_used = (deg5 == '0) ? CW'(1) : ((deg5 > MAXD) ? MAXD : deg5);
    assign o_req_ready = (r_state == S_IDLE);
    assign accept = i_req_valid && o_req_ready;
    assign idx_ok = (CW'(i_req_index) <= MAXD);
    assign o_rsp_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_stale  = r_stale;
        n_ovalid = r_ovalid && !i_rsp_ready;
        o_cmd    = '0;
        o_cmd.deg = n_used;
        o_cmd.idx = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_req_action == bpt_pkg::ACTION_LOAD) begin
                    o_cmd.load = 1'b1;
                    if (idx_ok) n_stale = 1'b1;
                end else if (accept) begin
                    o_cmd.cap = 1'b1;
                    n_state = r_stale ? S_INIT : S_HINIT;
                end
            end
            S_INIT: begin
                o_cmd.rb_init = 1'b1;
                n_cnt   = '0;
                n_state = S_PASCAL;
            end
            S_PASCAL: begin
                o_cmd.pascal = 1'b1;
                if (r_cnt == n_used - CW'(1)) begin
                    n_cnt   = '0;
                    n_state = S_DIFF;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                if (r_cnt == n_used) n_state = S_DRAIN;
                else n_cnt = r_cnt + CW'(1);
            end
            S_DRAIN: begin
                n_stale = 1'b0;
                n_state = S_HINIT;
            end
            S_HINIT: begin
                o_cmd.hinit = 1'b1;
                n_cnt   = n_used;
                n_state = S_HMUL;
            end
            S_HMUL: begin
                o_cmd.hmul = 1'b1;
                n_state = S_HADD;
            end
            S_HADD: begin
                o_cmd.hadd = 1'b1;
                n_cnt = r_cnt - CW'(1);
                n_state = (r_cnt == CW'(1)) ? S_OUT : S_HMUL;
            end
            S_OUT: begin
                if (!r_ovalid || i_rsp_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_stale = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_deg    <= bpt_pkg::DEG_W'(1);
            r_stale  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_stale  <= n_stale;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_deg <= i_cfg_wdata;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bpt_datapath.sv -----
// Datapath: control points, difference and binomial rows, coefficient stores,
// Horner accumulators and output registers. Depends on bpt_pkg.
`default_nettype none
module bpt_datapath #(
    parameter int MAX_DEGREE  = 8,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bpt_pkg::t_cmd                      i_cmd,
    input  wire logic [bpt_pkg::IDX_W-1:0]          i_point_index,
    input  wire logic signed [bpt_pkg::COORD_W-1:0] i_point_x,
    input  wire logic signed [bpt_pkg::COORD_W-1:0] i_point_y,
    input  wire logic [T_FRAC_BITS:0]               i_param_t,
    output logic signed [bpt_pkg::COORD_W-1:0]      o_pos_x,
    output logic signed [bpt_pkg::COORD_W-1:0]      o_pos_y,
    output logic signed [bpt_pkg::TAN_W-1:0]        o_tangent_x,
    output logic signed [bpt_pkg::TAN_W-1:0]        o_tangent_y
);
    localparam int NPTS = MAX_DEGREE + 1;
    localparam int CW   = $clog2(NPTS);
    localparam int SW   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int KW   = bpt_pkg::CNT_W;
    localparam int BW   = MAX_DEGREE;
    localparam int EW   = bpt_pkg::COEF_W;
    localparam int AW   = EW + CW + 1;
    localparam int TW   = T_FRAC_BITS + 1;
    localparam int PW   = AW + TW;
    localparam int QW   = AW + KW + 1;
    localparam int XW   = bpt_pkg::COORD_W;
    localparam int GW   = bpt_pkg::TAN_W;
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;
    localparam logic [PW-1:0] HALF  = PW'(1) << (T_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] P_HI = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] P_LO = AW'(-64'sd2147483648);
    localparam logic signed [QW-1:0] G_HI = QW'(64'sd549755813887);
    localparam logic signed [QW-1:0] G_LO = QW'(-64'sd549755813888);

    logic signed [XW-1:0] r_pt_x [NPTS];
    logic signed [XW-1:0] r_pt_y [NPTS];
    logic [EW-1:0]        r_d_x [NPTS];
    logic [EW-1:0]        r_d_y [NPTS];
    logic [BW-1:0]        r_b  [NPTS];
    logic [BW-1:0]        r_b1 [NPTS];
    logic signed [EW-1:0] r_pc_x [NPTS];
    logic signed [EW-1:0] r_pc_y [NPTS];
    logic signed [EW-1:0] r_sc_x [MAX_DEGREE];
    logic signed [EW-1:0] r_sc_y [MAX_DEGREE];
    logic                 r_wv;
    logic [CW-1:0]        r_widx;
    logic [EW-1:0]        r_pp_x, r_pp_y, r_ps_x, r_ps_y;
    logic [TW-1:0]        r_t;
    logic signed [AW-1:0] r_ap_x, r_ap_y, r_as_x, r_as_y;
    logic [PW-1:0]        r_mp_x, r_mp_y, r_ms_x, r_ms_y;
    logic                 r_np_x, r_np_y, r_ns_x, r_ns_y;

    logic [CW-1:0]        deg, idx, im1, dm1, wm1;
    logic                 pt_ok;
    logic signed [QW-1:0] tq_x, tq_y;

    assign deg   = CW'(i_cmd.deg);
    assign idx   = CW'(i_cmd.idx);
    assign im1   = idx - CW'(1);
    assign dm1   = deg - CW'(1);
    assign wm1   = r_widx - CW'(1);
    assign pt_ok = (KW'(i_point_index) <= KW'(MAX_DEGREE));
    assign tq_x  = QW'(r_as_x) * QW'($signed({1'b0, i_cmd.deg}));
    assign tq_y  = QW'(r_as_y) * QW'($signed({1'b0, i_cmd.deg}));

    function automatic logic [AW-1:0] f_mag(input logic signed [AW-1:0] a);
        return a[AW-1] ? AW'(-a) : AW'(a);
    endfunction

    function automatic logic signed [AW-1:0] f_round(input logic [PW-1:0] p,
                                                     input logic neg);
        logic [AW-1:0] r;
        r = AW'((p + HALF) >> T_FRAC_BITS);
        return neg ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [XW-1:0] f_sat_pos(input logic signed [AW-1:0] a);
        if (a > P_HI) return XW'(P_HI);
        if (a < P_LO) return XW'(P_LO);
        return XW'(a);
    endfunction

    function automatic logic signed [GW-1:0] f_sat_tan(input logic signed [QW-1:0] a);
        if (a > G_HI) return GW'(G_HI);
        if (a < G_LO) return GW'(G_LO);
        return GW'(a);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NPTS; j++) begin
                r_pt_x[j] <= '0;
                r_pt_y[j] <= '0;
            end
        end else if (i_cmd.load && pt_ok) begin
            r_pt_x[CW'(i_point_index)] <= i_point_x;
            r_pt_y[CW'(i_point_index)] <= i_point_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wv <= 1'b0;
        else r_wv <= i_cmd.diff;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) r_t <= (i_param_t > T_ONE) ? T_ONE : i_param_t;

        if (i_cmd.rb_init) begin
            for (int j = 0; j < NPTS; j++) begin
                r_d_x[j] <= EW'(r_pt_x[j]);
                r_d_y[j] <= EW'(r_pt_y[j]);
                r_b[j]   <= (j == 0) ? BW'(1) : '0;
            end
        end
        if (i_cmd.pascal) begin
            for (int j = 0; j < NPTS; j++) begin
                r_b1[j] <= r_b[j];
                if (j > 0) r_b[j] <= r_b[j] + r_b[j-1];
            end
        end
        if (i_cmd.diff) begin
            for (int j = 0; j < NPTS - 1; j++) begin
                r_d_x[j] <= r_d_x[j+1] - r_d_x[j];
                r_d_y[j] <= r_d_y[j+1] - r_d_y[j];
            end
            r_pp_x <= EW'(r_d_x[0] * EW'(r_b[idx]));
            r_pp_y <= EW'(r_d_y[0] * EW'(r_b[idx]));
            r_ps_x <= EW'(r_d_x[0] * EW'(r_b1[im1]));
            r_ps_y <= EW'(r_d_y[0] * EW'(r_b1[im1]));
            r_widx <= idx;
        end
        if (r_wv) begin
            r_pc_x[r_widx] <= r_pp_x;
            r_pc_y[r_widx] <= r_pp_y;
            if (r_widx != '0) begin
                r_sc_x[wm1[SW-1:0]] <= r_ps_x;
                r_sc_y[wm1[SW-1:0]] <= r_ps_y;
            end
        end

        if (i_cmd.hinit) begin
            r_ap_x <= AW'(r_pc_x[deg]);
            r_ap_y <= AW'(r_pc_y[deg]);
            r_as_x <= AW'(r_sc_x[dm1[SW-1:0]]);
            r_as_y <= AW'(r_sc_y[dm1[SW-1:0]]);
        end
        if (i_cmd.hmul) begin
            r_mp_x <= PW'(f_mag(r_ap_x)) * PW'(r_t);
            r_mp_y <= PW'(f_mag(r_ap_y)) * PW'(r_t);
            r_ms_x <= PW'(f_mag(r_as_x)) * PW'(r_t);
            r_ms_y <= PW'(f_mag(r_as_y)) * PW'(r_t);
            r_np_x <= r_ap_x[AW-1];
            r_np_y <= r_ap_y[AW-1];
            r_ns_x <= r_as_x[AW-1];
            r_ns_y <= r_as_y[AW-1];
        end
        if (i_cmd.hadd) begin
            r_ap_x <= f_round(r_mp_x, r_np_x) + AW'(r_pc_x[im1]);
            r_ap_y <= f_round(r_mp_y, r_np_y) + AW'(r_pc_y[im1]);
            if (idx != deg) begin
                r_as_x <= f_round(r_ms_x, r_ns_x) + AW'(r_sc_x[im1[SW-1:0]]);
                r_as_y <= f_round(r_ms_y, r_ns_y) + AW'(r_sc_y[im1[SW-1:0]]);
            end
        end

        if (i_cmd.out_load) begin
            o_pos_x     <= f_sat_pos(r_ap_x);
            o_pos_y     <= f_sat_pos(r_ap_y);
            o_tangent_x <= f_sat_tan(tq_x);
            o_tangent_y <= f_sat_tan(tq_y);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/bezier_point_and_tangent_unit.sv -----
// Top level of the Bezier point and tangent unit: controller plus datapath.
// Depends on bpt_pkg, bpt_req_if, bpt_rsp_if, bpt_ctrl and bpt_datapath.
//
// A load request (action 0) stores one control point and gives no
// result. An evaluate request returns the curve point and tangent at t.
// When a point or the degree has changed since the last evaluation, the
// power-basis coefficients are first rebuilt: a set-up step, the binomial
// row build, the forward differences and a drain step. Evaluation then
// takes a multiply and a round-and-add for each Horner step, shared
// by all four chains. A result is held in an output register until taken
// while further requests are accepted.
`default_nettype none
module bezier_point_and_tangent_unit #(
    parameter int MAX_DEGREE  = 8,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [bpt_pkg::DEG_W-1:0] i_cfg_wdata,
    bpt_req_if.sink                        i_req,
    bpt_rsp_if.source                      o_rsp
);
    bpt_pkg::t_cmd cmd;

    bpt_ctrl #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (i_req.valid),
        .o_req_ready  (i_req.ready),
        .i_req_action (i_req.action),
        .i_req_index  (i_req.point_index),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_cmd        (cmd)
    );

    bpt_datapath #(
        .MAX_DEGREE  (MAX_DEGREE),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_point_index (i_req.point_index),
        .i_point_x     (i_req.point_x),
        .i_point_y     (i_req.point_y),
        .i_param_t     (i_req.param_t),
        .o_pos_x       (o_rsp.pos_x),
        .o_pos_y       (o_rsp.pos_y),
        .o_tangent_x   (o_rsp.tangent_x),
        .o_tangent_y   (o_rsp.tangent_y)
    );

    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.action == bpt_pkg::ACTION_EVAL)
        |=> !i_req.ready)
        else $error("unit ready straight after evaluate request");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.action == bpt_pkg::ACTION_LOAD)
        |=> i_req.ready)
        else $error("load request left the unit busy");

    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.action == bpt_pkg::ACTION_EVAL)
        |=> !$rose(o_rsp.valid))
        else $error("result raised one cycle after evaluate request");

endmodule
`default_nettype wire
